// ===== src/xtq_pkg.sv =====
// Shared constants, types and codes for the XOR trie min/max query block.
package xtq_pkg;

  localparam int KEY_BITS   = 16;
  localparam int MAX_NODES  = 4096;
  localparam int COUNT_BITS = 16;

  localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DEPTH_W = $clog2(KEY_BITS + 1);

  typedef logic [NODE_W-1:0]     node_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [DEPTH_W-1:0]    depth_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  // Operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_MIN_XOR = 2'd2;
  localparam logic [1:0] OP_MAX_XOR = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    node_idx_t ch1;
    node_idx_t ch0;
    count_t    cnt;
  } node_t;

  typedef struct packed {
    logic      we;
    node_idx_t addr;
    node_t     data;
  } mem_wr_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] xor_result;
    logic [1:0]  status;
  } out_item_t;

endpackage

// ===== src/xtq_node_mem.sv =====
// Trie node pool: one write port, one read port with registered read data.
module xtq_node_mem import xtq_pkg::*; (
  input  logic      clk,
  input  mem_wr_t   wr,
  input  node_idx_t rd_addr,
  output node_t     rd_data_r
);

  node_t mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== src/xtq_node_upd.sv =====
// Shared node update unit: count increment/decrement and child allocation.
module xtq_node_upd import xtq_pkg::*; (
  input  node_t     ent_i,
  input  logic      ins_i,
  input  logic      dir_i,
  input  logic      leaf_i,
  input  node_idx_t new_idx_i,
  output node_t     ent_o,
  output logic      alloc_o
);

  always_comb begin
    ent_o   = ent_i;
    alloc_o = 1'b0;
    if (ins_i) begin
      ent_o.cnt = ent_i.cnt + count_t'(1);
      if (!leaf_i) begin
        if (dir_i) begin
          if (ent_i.ch1 == '0) begin
            ent_o.ch1 = new_idx_i;
            alloc_o   = 1'b1;
          end
        end else begin
          if (ent_i.ch0 == '0) begin
            ent_o.ch0 = new_idx_i;
            alloc_o   = 1'b1;
          end
        end
      end
    end else begin
      ent_o.cnt = ent_i.cnt - count_t'(1);
    end
  end

endmodule

// ===== src/xor_trie_min_max_query.sv =====
// Top level: sequencer walking the trie node pool one level at a time.
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, in_data    | input     | in_item_t (operation, value)
//  out     | out_valid, out_ready, out_data | output    | out_item_t (xor_result, status)
//
// Insert/remove: a check walk reading each node on the path (S_SCAN, S_SCAN_W), then an
// update walk (S_UPD) that reads existing nodes through S_UPD_W but not fresh ones.
// Queries read the preferred child (S_QRY_P), and the other one when it is empty (S_QRY_W).
// The walks are paced by the single node pool read port and its registered data.
// Reset clears the root node and the allocation count; no pool clearing pass.
// A new transfer is taken while the previous result still waits at out.
module xor_trie_min_max_query import xtq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_SCAN_W = 9'b000000100,
    S_UPD    = 9'b000001000,
    S_UPD_W  = 9'b000010000,
    S_QRY    = 9'b000100000,
    S_QRY_P  = 9'b001000000,
    S_QRY_W  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  localparam int CHK_W = NODE_W + DEPTH_W + 1;

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  key_t       key_r, key_nxt;
  key_t       sh_r, sh_nxt;
  depth_t     d_r, d_nxt;
  node_t      cur_r, cur_nxt;
  node_idx_t  cur_idx_r, cur_idx_nxt;
  node_idx_t  fetch_idx_r, fetch_idx_nxt;
  key_t       res_r, res_nxt;
  logic [1:0] status_r, status_nxt;
  node_t      root_r, root_nxt;
  node_idx_t  nodes_used_r, nodes_used_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  mem_wr_t    mem_wr;
  node_idx_t  rd_addr;
  node_t      rd_data;
  node_t      fetched;

  node_t      upd_ent;
  logic       upd_alloc;
  node_idx_t  new_idx;

  logic       bit_cur, want_max, pref, last, leaf;
  node_idx_t  p_idx, q_idx, c_idx, n_idx;
  depth_t     missing;
  logic [CHK_W-1:0] need_sum;

  xtq_node_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  xtq_node_upd u_upd (
    .ent_i     (cur_r),
    .ins_i     (op_r == OP_INSERT),
    .dir_i     (bit_cur),
    .leaf_i    (leaf),
    .new_idx_i (new_idx),
    .ent_o     (upd_ent),
    .alloc_o   (upd_alloc)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bit_cur  = sh_r[KEY_BITS-1];
  assign want_max = (op_r == OP_MAX_XOR);
  assign pref     = bit_cur ^ want_max;
  assign p_idx    = pref ? cur_r.ch1 : cur_r.ch0;
  assign q_idx    = pref ? cur_r.ch0 : cur_r.ch1;
  assign c_idx    = bit_cur ? cur_r.ch1 : cur_r.ch0;
  assign n_idx    = bit_cur ? upd_ent.ch1 : upd_ent.ch0;
  assign last     = (d_r == depth_t'(KEY_BITS - 1));
  assign leaf     = (d_r == depth_t'(KEY_BITS));
  assign new_idx  = nodes_used_r + node_idx_t'(1);
  assign missing  = depth_t'(KEY_BITS) - d_r;
  assign need_sum = CHK_W'(nodes_used_r) + CHK_W'(missing);
  // node 0 lives in registers, not in the pool
  assign fetched  = (fetch_idx_r == '0) ? root_r : rd_data;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    sh_nxt         = sh_r;
    d_nxt          = d_r;
    cur_nxt        = cur_r;
    cur_idx_nxt    = cur_idx_r;
    fetch_idx_nxt  = fetch_idx_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    root_nxt       = root_r;
    nodes_used_nxt = nodes_used_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_wr         = '0;
    rd_addr        = cur_idx_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.operation;
          key_nxt     = KEY_BITS'(in_data.value);
          sh_nxt      = KEY_BITS'(in_data.value);
          d_nxt       = '0;
          cur_nxt     = root_r;
          cur_idx_nxt = '0;
          res_nxt     = '0;
          status_nxt  = ST_OK;
          case (in_data.operation)
            OP_INSERT: begin
              if (root_r.cnt == COUNT_MAX) begin
                status_nxt = ST_FULL;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_REMOVE: begin
              if (root_r.cnt == '0) begin
                status_nxt = ST_ABSENT;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (root_r.cnt == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_QRY;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (c_idx == '0) begin
          if (op_r == OP_INSERT) begin
            if (need_sum > CHK_W'(MAX_NODES - 1)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FINISH;
            end else begin
              cur_nxt     = root_r;
              cur_idx_nxt = '0;
              d_nxt       = '0;
              sh_nxt      = key_r;
              state_nxt   = S_UPD;
            end
          end else begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_FINISH;
          end
        end else begin
          rd_addr       = c_idx;
          fetch_idx_nxt = c_idx;
          state_nxt     = S_SCAN_W;
        end
      end

      S_SCAN_W: begin
        if (op_r == OP_REMOVE && fetched.cnt == '0) begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_FINISH;
        end else if (last) begin
          // whole path present: start the update walk at the root
          cur_nxt     = root_r;
          cur_idx_nxt = '0;
          d_nxt       = '0;
          sh_nxt      = key_r;
          state_nxt   = S_UPD;
        end else begin
          cur_nxt     = fetched;
          cur_idx_nxt = fetch_idx_r;
          d_nxt       = d_r + depth_t'(1);
          sh_nxt      = KEY_BITS'({sh_r, 1'b0});
          state_nxt   = S_SCAN;
        end
      end

      S_UPD: begin
        if (cur_idx_r == '0) begin
          root_nxt = upd_ent;
        end else begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = cur_idx_r;
          mem_wr.data = upd_ent;
        end
        if (upd_alloc) begin
          nodes_used_nxt = new_idx;
        end
        if (leaf) begin
          state_nxt = S_FINISH;
        end else begin
          d_nxt       = d_r + depth_t'(1);
          sh_nxt      = KEY_BITS'({sh_r, 1'b0});
          cur_idx_nxt = n_idx;
          if (upd_alloc) begin
            // freshly allocated node: stale pool contents are not read
            cur_nxt = '0;
          end else begin
            rd_addr       = n_idx;
            fetch_idx_nxt = n_idx;
            state_nxt     = S_UPD_W;
          end
        end
      end

      S_UPD_W: begin
        cur_nxt   = fetched;
        state_nxt = S_UPD;
      end

      S_QRY: begin
        if (p_idx == '0) begin
          res_nxt = KEY_BITS'({res_r, ~want_max});
          if (last) begin
            state_nxt = S_FINISH;
          end else begin
            rd_addr       = q_idx;
            fetch_idx_nxt = q_idx;
            cur_idx_nxt   = q_idx;
            d_nxt         = d_r + depth_t'(1);
            sh_nxt        = KEY_BITS'({sh_r, 1'b0});
            state_nxt     = S_QRY_W;
          end
        end else begin
          rd_addr       = p_idx;
          fetch_idx_nxt = p_idx;
          state_nxt     = S_QRY_P;
        end
      end

      S_QRY_P: begin
        if (fetched.cnt != '0) begin
          res_nxt = KEY_BITS'({res_r, want_max});
          if (last) begin
            state_nxt = S_FINISH;
          end else begin
            cur_nxt     = fetched;
            cur_idx_nxt = fetch_idx_r;
            d_nxt       = d_r + depth_t'(1);
            sh_nxt      = KEY_BITS'({sh_r, 1'b0});
            state_nxt   = S_QRY;
          end
        end else begin
          // preferred child is empty: fall back to the other one
          res_nxt = KEY_BITS'({res_r, ~want_max});
          if (last) begin
            state_nxt = S_FINISH;
          end else begin
            rd_addr       = q_idx;
            fetch_idx_nxt = q_idx;
            cur_idx_nxt   = q_idx;
            d_nxt         = d_r + depth_t'(1);
            sh_nxt        = KEY_BITS'({sh_r, 1'b0});
            state_nxt     = S_QRY_W;
          end
        end
      end

      S_QRY_W: begin
        cur_nxt   = fetched;
        state_nxt = S_QRY;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.xor_result = 16'(res_r);
          out_data_nxt.status     = status_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      root_r       <= '0;
      nodes_used_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      root_r       <= root_nxt;
      nodes_used_r <= nodes_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    sh_r        <= sh_nxt;
    d_r         <= d_nxt;
    cur_r       <= cur_nxt;
    cur_idx_r   <= cur_idx_nxt;
    fetch_idx_r <= fetch_idx_nxt;
    res_r       <= res_nxt;
    status_r    <= status_nxt;
    out_data_r  <= out_data_nxt;
  end

  // allocation count only grows between resets
  a_nodes_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> nodes_used_r >= $past(nodes_used_r))
    else $error("node allocation count went down");

  // root occupancy changes only during the update walk
  a_root_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (root_r.cnt != $past(root_r.cnt)) |-> $past(state_r) == S_UPD)
    else $error("root count changed outside update walk");

  // a result is presented only after the finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result transfer raised outside finish step");

  // walk depth never passes the leaf level
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> d_r <= depth_t'(KEY_BITS))
    else $error("walk depth out of range");

endmodule

// ===== bench/xor_trie_min_max_query_tb.sv =====
// Self-checking bench for the XOR trie block: directed walk, random traffic, pool exhaustion.
`timescale 1ns / 1ps

module xor_trie_min_max_query_tb;
  import xtq_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 860;

  // Trie shadow plus the in-order list of results still owed by the block.
  class trie_scoreboard;
    bit [NODE_W-1:0]     kid0 [MAX_NODES];
    bit [NODE_W-1:0]     kid1 [MAX_NODES];
    bit [COUNT_BITS-1:0] occ  [MAX_NODES];
    int unsigned         nodes_taken;
    out_item_t           awaited[$];
    int unsigned         mismatches;
    int unsigned         full_rejects;

    function bit [NODE_W-1:0] kid_of(int unsigned n, bit b);
      return b ? kid1[n] : kid0[n];
    endfunction

    // Root count saturation is modeled but needs 65535 live keys to reach.
    function logic [1:0] insert_key(key_t k);
      int unsigned cur;
      int unsigned nxt;
      int unsigned need;
      int          lvl;
      bit          walking;
      if (occ[0] == COUNT_MAX) return ST_FULL;
      cur = 0;
      need = 0;
      walking = 1'b1;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        if (walking) begin
          nxt = kid_of(cur, k[lvl]);
          if (nxt == 0) begin
            need = lvl + 1;
            walking = 1'b0;
          end else begin
            cur = nxt;
          end
        end
      end
      if (nodes_taken + need > MAX_NODES - 1) return ST_FULL;
      cur = 0;
      occ[0]++;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        if (kid_of(cur, k[lvl]) == 0) begin
          nodes_taken++;
          if (k[lvl]) kid1[cur] = node_idx_t'(nodes_taken);
          else kid0[cur] = node_idx_t'(nodes_taken);
        end
        cur = kid_of(cur, k[lvl]);
        occ[cur]++;
      end
      return ST_OK;
    endfunction

    function logic [1:0] remove_key(key_t k);
      int unsigned cur;
      int unsigned nxt;
      int          lvl;
      bit          found;
      if (occ[0] == 0) return ST_ABSENT;
      cur = 0;
      found = 1'b1;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        if (found) begin
          nxt = kid_of(cur, k[lvl]);
          if (nxt == 0 || occ[nxt] == 0) found = 1'b0;
          else cur = nxt;
        end
      end
      if (!found) return ST_ABSENT;
      cur = 0;
      occ[0]--;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        cur = kid_of(cur, k[lvl]);
        occ[cur]--;
      end
      return ST_OK;
    endfunction

    // Greedy descent; a child with zero count is as good as missing.
    function key_t best_xor(key_t k, bit want_max);
      key_t        res;
      int unsigned cur;
      int unsigned p;
      int          lvl;
      bit          pref;
      res = '0;
      cur = 0;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        pref = k[lvl] ^ want_max;
        p = kid_of(cur, pref);
        if (p != 0 && occ[p] != 0) begin
          cur = p;
          if (want_max) res[lvl] = 1'b1;
        end else begin
          cur = kid_of(cur, !pref);
          if (!want_max) res[lvl] = 1'b1;
        end
      end
      return res;
    endfunction

    function void note_request(in_item_t it);
      out_item_t due;
      key_t      k;
      k = it.value[KEY_BITS-1:0];
      due.xor_result = '0;
      case (it.operation)
        OP_INSERT: due.status = insert_key(k);
        OP_REMOVE: due.status = remove_key(k);
        default: begin
          if (occ[0] == 0) begin
            due.status = ST_EMPTY;
          end else begin
            due.status = ST_OK;
            due.xor_result = best_xor(k, it.operation == OP_MAX_XOR);
          end
        end
      endcase
      if (due.status == ST_FULL) full_rejects++;
      awaited.push_back(due);
    endfunction

    function void check_response(out_item_t got);
      out_item_t due;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: xor_result %h status %0d",
               got.xor_result, got.status);
        mismatches++;
        return;
      end
      due = awaited.pop_front();
      if (got.xor_result !== due.xor_result) begin
        $error("xor_result: expected %h, got %h", due.xor_result, got.xor_result);
        mismatches++;
      end
      if (got.status !== due.status) begin
        $error("status: expected %0d, got %0d", due.status, got.status);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  trie_scoreboard sb;
  bit             no_idle;
  bit             hold_off_req;
  int unsigned    issued;
  key_t           live[$];
  key_t           hubs[6];

  xor_trie_min_max_query DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Results are owed in order, so check before noting a same-edge transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_response(out_data);
      if (in_valid && in_ready) sb.note_request(in_data);
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic offer(logic [1:0] op, key_t v);
    in_item_t it;
    it.operation = op;
    it.value = v;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Sender holds off until the block has returned everything owed.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Narrow keys share long prefixes so paths overlap and counts go deep.
  function automatic key_t pick_key(bit wide);
    key_t k;
    if (!wide && $urandom_range(0, 9) < 7) begin
      k = hubs[$urandom_range(0, 5)];
      k[5:0] = 6'($urandom_range(0, 63));
    end else if (live.size() > 0 && $urandom_range(0, 3) == 0) begin
      k = live[$urandom_range(0, live.size() - 1)];
    end else begin
      k = key_t'($urandom);
    end
    return k;
  endfunction

  task automatic mixed_op(int ins_pct, int rem_pct, bit wide);
    int   r;
    int   idx;
    key_t k;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      k = pick_key(wide);
      live.push_back(k);
      offer(OP_INSERT, k);
    end else if (r < ins_pct + rem_pct) begin
      if (live.size() > 0 && $urandom_range(0, 5) != 0) begin
        idx = $urandom_range(0, live.size() - 1);
        k = live[idx];
        live.delete(idx);
      end else begin
        k = pick_key(wide);
      end
      offer(OP_REMOVE, k);
    end else begin
      if (live.size() > 0 && $urandom_range(0, 1) == 0)
        k = live[$urandom_range(0, live.size() - 1)] ^ key_t'($urandom_range(0, 255));
      else
        k = key_t'($urandom);
      offer($urandom_range(0, 1) ? OP_MAX_XOR : OP_MIN_XOR, k);
    end
  endtask

  initial begin
    int n;
    sb = new();
    no_idle = 1'b0;
    hold_off_req = 1'b0;
    issued = 0;
    for (n = 0; n < 6; n++) hubs[n] = key_t'($urandom);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty set, absent keys, duplicates, drained paths left behind
    offer(OP_MIN_XOR, 16'h0000);
    offer(OP_MAX_XOR, 16'hFFFF);
    offer(OP_REMOVE,  16'h1234);
    offer(OP_INSERT,  16'h0000);
    offer(OP_INSERT,  16'hFFFF);
    offer(OP_INSERT,  16'hFFFF);
    offer(OP_MIN_XOR, 16'h0000);
    offer(OP_MAX_XOR, 16'h0000);
    offer(OP_MIN_XOR, 16'hFFFF);
    offer(OP_MAX_XOR, 16'h8000);
    offer(OP_REMOVE,  16'h1234);
    offer(OP_REMOVE,  16'hFFFF);
    offer(OP_MAX_XOR, 16'h0000);
    offer(OP_REMOVE,  16'hFFFF);
    offer(OP_REMOVE,  16'hFFFF);
    offer(OP_MAX_XOR, 16'h0000);
    offer(OP_MIN_XOR, 16'hFFFF);
    offer(OP_INSERT,  16'hA5A5);
    offer(OP_INSERT,  16'h5A5A);
    offer(OP_MIN_XOR, 16'hA5A4);
    offer(OP_MAX_XOR, 16'h5A5B);
    offer(OP_REMOVE,  16'h0000);
    offer(OP_REMOVE,  16'hA5A5);
    offer(OP_REMOVE,  16'h5A5A);
    offer(OP_MIN_XOR, 16'h1111);
    settle();

    // clustered traffic, starting under a long receiver stall
    hold_off_req = 1'b1;
    repeat (200) mixed_op(35, 30, 1'b0);
    settle();

    // mostly wide inserts until the node pool runs out
    n = 0;
    while (sb.full_rejects < 20 && n < 500) begin
      mixed_op(85, 5, 1'b1);
      n++;
    end
    settle();

    // full pool: known keys still go in, new ones are refused
    no_idle = 1'b1;
    n = 0;
    while (n < 100 || issued < ITEM_TARGET) begin
      mixed_op(40, 30, 1'b1);
      n++;
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * KEY_BITS + 8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("xor_trie_min_max_query regression: pass");
    else
      $display("xor_trie_min_max_query regression: fail");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("xor_trie_min_max_query regression: fail");
    $finish;
  end

endmodule
